// ----- design/iparm_pkg.sv -----
// Shared types, constants and codes for the IP access rule matcher.
package iparm_pkg;

	localparam int RuleSlotsDefault  = 32;
	localparam int ClassSlotsDefault = 8;
	localparam logic [15:0] UsageTop = 16'hFFFF;

	typedef enum logic [2:0] {
		ACT_LOAD_RULE  = 3'd0,
		ACT_LOAD_CLASS = 3'd1,
		ACT_CONNECT    = 3'd2,
		ACT_RECOUNT    = 3'd3,
		ACT_RELEASE    = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		VERDICT_OK      = 2'd0,
		VERDICT_FULL    = 2'd1,
		VERDICT_NOMATCH = 2'd2,
		VERDICT_DONE    = 2'd3
	} verdict_t;

	localparam logic REG_RULES_IN_USE   = 1'b0;
	localparam logic REG_CLASSES_IN_USE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_CLASS,
		ST_OUT
	} state_t;

	// Search word that travels down the rule chain
	typedef struct packed {
		logic        live;
		logic        found;
		logic [2:0]  cls;
		logic [31:0] addr;
		logic [4:0]  hour;
		logic [2:0]  wday;
	} probe_t;

	// One rule as held in a cell
	typedef struct packed {
		logic [31:0] addr;
		logic [31:0] mask;
		logic        timed;
		logic [23:0] hours;
		logic [6:0]  days;
		logic [2:0]  cls;
	} rule_t;

endpackage

// ----- design/iparm_cell.sv -----
// One rule cell: holds a rule and tests the probe word passing through.
module iparm_cell #(
	parameter int ClassSlots = iparm_pkg::ClassSlotsDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr,
	input  iparm_pkg::rule_t   wr_rule,
	input  logic               enable,
	input  iparm_pkg::probe_t  probe_in,
	output iparm_pkg::probe_t  probe_out
);
	import iparm_pkg::*;

	rule_t  rule_q;
	probe_t probe_q;
	logic   hit;

	// Hold the rule written by load
	always_ff @(posedge clk) begin
		if (wr) begin
			rule_q <= wr_rule;
		end
	end

	// Match address, class range and time window
	always_comb begin
		hit = (((rule_q.addr ^ probe_in.addr) & rule_q.mask) == 32'd0)
			&& (32'(rule_q.cls) < ClassSlots);
		if (rule_q.timed) begin
			if (probe_in.hour >= 5'd24 || !rule_q.hours[probe_in.hour]) hit = 1'b0;
			if (probe_in.wday >= 3'd7 || !rule_q.days[probe_in.wday]) hit = 1'b0;
		end
	end

	// Pass the probe on, marking the first hit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q <= '0;
		end else begin
			probe_q.live  <= probe_in.live;
			probe_q.found <= probe_in.found || (enable && probe_in.live && hit);
			probe_q.addr  <= probe_in.addr;
			probe_q.hour  <= probe_in.hour;
			probe_q.wday  <= probe_in.wday;
			probe_q.cls   <= (probe_in.found || !(enable && hit)) ? probe_in.cls : rule_q.cls;
		end
	end

	assign probe_out = probe_q;

endmodule

// ----- design/ip_access_rule_matcher.sv -----
// Top level: rule cell chain, class table and control sequencer.
// Load and release go from idle through the class step to the result; connect and recount
// first walk the probe down the chain, one rule cell per cycle, before the class step.
// Throughput: one word at a time; the next input is taken once the result is taken.
// Reset clears the registers, class usage and control; rule and class ids are
// undefined until loaded.
module ip_access_rule_matcher #(
	parameter int RULE_SLOTS  = iparm_pkg::RuleSlotsDefault,
	parameter int CLASS_SLOTS = iparm_pkg::ClassSlotsDefault
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [5:0]   cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// action[2:0], slot[7:3], address[39:8], address_mask[71:40], time_limited[72],
	// hours_allowed[96:73], days_allowed[103:97], target_class[106:104],
	// class_number[122:107], usage_limit[138:123], hour_now[143:139],
	// weekday_now[146:144], zero fill to 152
	input  logic [151:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// verdict[1:0], granted_class[17:2], matched_slot[20:18], zero fill to 24
	output logic [23:0]  m_tdata
);
	import iparm_pkg::*;

	localparam int CW = (CLASS_SLOTS > 1) ? $clog2(CLASS_SLOTS) : 1;
	localparam int NW = $clog2(RULE_SLOTS + 1);

	state_t state_q, state_n;
	logic [5:0] rules_q;
	logic [3:0] classes_q;
	logic [NW:0] cnt_q;
	logic [2:0] act_q;
	logic [15:0] cnum_q;
	verdict_t verdict_q;
	logic [15:0] granted_q;
	logic [2:0] mslot_q;
	logic found_q;
	logic [2:0] cls_q;
	logic [15:0] cid_q [CLASS_SLOTS];
	logic [15:0] clim_q [CLASS_SLOTS];
	logic [15:0] cuse_q [CLASS_SLOTS];
	probe_t chain [RULE_SLOTS+1];
	rule_t new_rule;
	logic accept;
	logic [CW-1:0] ci;
	logic [5:0] rules_eff;
	logic [3:0] classes_eff;
	logic rel_hit;
	logic [CW-1:0] rel_idx;

	wire [2:0]  in_act  = s_tdata[2:0];
	wire [4:0]  in_slot = s_tdata[7:3];

	assign accept = s_tvalid && s_tready;
	assign new_rule = '{addr: s_tdata[39:8], mask: s_tdata[71:40], timed: s_tdata[72],
		hours: s_tdata[96:73], days: s_tdata[103:97], cls: s_tdata[106:104]};
	assign rules_eff = (32'(rules_q) > RULE_SLOTS) ? 6'(RULE_SLOTS) : rules_q;
	assign classes_eff = (32'(classes_q) > CLASS_SLOTS) ? 4'(CLASS_SLOTS) : classes_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rules_q <= '0;
			classes_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_RULES_IN_USE) rules_q <= cfg_data;
			else classes_q <= cfg_data[3:0];
		end
	end

	// Inject the probe at the chain head
	always_comb begin
		chain[0].live = accept && (in_act == ACT_CONNECT || in_act == ACT_RECOUNT);
		chain[0].found = 1'b0;
		chain[0].cls = '0;
		chain[0].addr = s_tdata[39:8];
		chain[0].hour = s_tdata[143:139];
		chain[0].wday = s_tdata[146:144];
	end

	for (genvar g = 0; g < RULE_SLOTS; g++) begin : g_cell
		iparm_cell #(.ClassSlots(CLASS_SLOTS)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.wr(accept && in_act == ACT_LOAD_RULE && 32'(in_slot) == g),
			.wr_rule(new_rule),
			.enable(g < 32'(rules_eff)),
			.probe_in(chain[g]),
			.probe_out(chain[g+1])
		);
	end

	// Capture the probe as it leaves the last cell
	always_ff @(posedge clk) begin
		if (state_q == ST_WALK && cnt_q == (NW+1)'(RULE_SLOTS - 1)) begin
			found_q <= chain[RULE_SLOTS].found;
			cls_q <= chain[RULE_SLOTS].cls;
		end
	end

	assign ci = CW'(cls_q);

	// Find first class in use with a matching id
	always_comb begin
		rel_hit = 1'b0;
		rel_idx = '0;
		for (int i = CLASS_SLOTS - 1; i >= 0; i--) begin
			if (i < 32'(classes_eff) && cid_q[i] == cnum_q) begin
				rel_hit = 1'b1;
				rel_idx = CW'(i);
			end
		end
	end

	// Sequencer next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE:  if (accept) state_n = chain[0].live ? ST_WALK : ST_CLASS;
			ST_WALK:  if (cnt_q == (NW+1)'(RULE_SLOTS - 1)) state_n = ST_CLASS;
			ST_CLASS: state_n = ST_OUT;
			ST_OUT:   if (m_tready) state_n = ST_IDLE;
			default:  state_n = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		m_tvalid = (state_q == ST_OUT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_n;
			cnt_q <= (state_q == ST_WALK) ? cnt_q + 1'b1 : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= in_act;
			cnum_q <= s_tdata[122:107];
		end
	end

	// Class table update and verdict
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CLASS_SLOTS; i++) cuse_q[i] <= '0;
		end else begin
			if (accept && in_act == ACT_LOAD_CLASS && 32'(in_slot) < CLASS_SLOTS)
				cuse_q[CW'(in_slot)] <= '0;
			if (state_q == ST_CLASS) begin
				if ((act_q == ACT_CONNECT || act_q == ACT_RECOUNT) && found_q
					&& !(act_q == ACT_CONNECT && cuse_q[ci] >= clim_q[ci])
					&& cuse_q[ci] != UsageTop)
					cuse_q[ci] <= cuse_q[ci] + 16'd1;
				if (act_q == ACT_RELEASE && rel_hit && cuse_q[rel_idx] != 16'd0)
					cuse_q[rel_idx] <= cuse_q[rel_idx] - 16'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_act == ACT_LOAD_CLASS && 32'(in_slot) < CLASS_SLOTS) begin
			cid_q[CW'(in_slot)] <= s_tdata[122:107];
			clim_q[CW'(in_slot)] <= s_tdata[138:123];
		end
		if (state_q == ST_CLASS) begin
			verdict_q <= VERDICT_DONE;
			granted_q <= '0;
			mslot_q <= '0;
			if (act_q == ACT_CONNECT || act_q == ACT_RECOUNT) begin
				if (!found_q) begin
					verdict_q <= VERDICT_NOMATCH;
				end else begin
					granted_q <= cid_q[ci];
					mslot_q <= cls_q;
					verdict_q <= (act_q == ACT_CONNECT && cuse_q[ci] >= clim_q[ci])
						? VERDICT_FULL : VERDICT_OK;
				end
			end
		end
	end

	assign m_tdata = {3'b000, mslot_q, granted_q, verdict_q};

`ifndef NO_ASSERTIONS
	a_out_after_class: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLASS |=> m_tvalid) else $error("result not presented");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !s_tready) else $error("input taken while busy");
	a_probe_arrives: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK && cnt_q == (NW+1)'(RULE_SLOTS - 1) |-> chain[RULE_SLOTS].live)
		else $error("probe not at chain end");
`endif

endmodule
